// ----- sv/rmq_pkg.sv -----
// Shared constants, types and codes for the rotation matrix to quaternion block.
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int IN_W      = 16;
   localparam int OUT_W     = 16;
   localparam int ONE       = 1 << FRAC_BITS;

   // radicand before the fraction shift, unsigned
   localparam int RAD_W   = (FRAC_BITS > 17) ? FRAC_BITS + 1 : 18;
   localparam int SUM_W   = RAD_W + 1;
   localparam int SQ_IN_W = ((RAD_W + FRAC_BITS + 1) / 2) * 2;
   localparam int S_W     = SQ_IN_W / 2;
   localparam int REM_W   = S_W + 1;
   localparam int CUR_W   = S_W + 3;

   // off-diagonal sums and differences, as magnitudes
   localparam int D_W   = IN_W + 1;
   localparam int MAG_W = D_W + FRAC_BITS;
   localparam int Q_W   = 16;
   localparam int DW    = (MAG_W > S_W + 1 + Q_W) ? MAG_W : S_W + 1 + Q_W;
   localparam int NSLOT = 3;

   localparam int SAT_HI     = (ONE < 32767) ? ONE : 32767;
   localparam int SAT_LO_MAG = (ONE < 32768) ? ONE : 32768;

   // input register, prep register, root stages, quotient stages, output register
   localparam int LATENCY = 2 + S_W + Q_W + 1;

   typedef enum logic [1:0] {
      CASE_TRACE = 2'd0,
      CASE_X     = 2'd1,
      CASE_Y     = 2'd2,
      CASE_Z     = 2'd3
   } case_type;

   typedef struct packed {
      case_type                       kase;
      logic [NSLOT-1:0]               neg;
      logic [NSLOT-1:0][D_W-1:0]      mag;
   } side_type;

endpackage

// ----- sv/rmq_prep.sv -----
// Input register, trace and branch select, radicand and off-diagonal terms.
module rmq_prep import rmq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [8:0][IN_W-1:0]  in_m,
   output logic                  out_valid,
   output logic [SQ_IN_W-1:0]    out_rad,
   output side_type              out_side
);

   logic                 in_valid_ff;
   logic [8:0][IN_W-1:0] m_ff;
   logic                 valid_ff;
   logic [SQ_IN_W-1:0]   rad_ff, rad_in;
   side_type             side_ff, side_in;

   function automatic logic signed [SUM_W-1:0] sext(input logic [IN_W-1:0] v);
      return signed'({{(SUM_W-IN_W){v[IN_W-1]}}, v});
   endfunction

   logic signed [SUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [SUM_W-1:0] tr, rad_s;
   logic signed [SUM_W-1:0] d_x, d_y, d_z, d_w;
   logic signed [SUM_W-1:0] sa, sb, sc;

   function automatic logic [D_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] a;
      a = v[SUM_W-1] ? -v : v;
      return a[D_W-1:0];
   endfunction

   always_comb begin
      e00 = sext(m_ff[0]); e01 = sext(m_ff[1]); e02 = sext(m_ff[2]);
      e10 = sext(m_ff[3]); e11 = sext(m_ff[4]); e12 = sext(m_ff[5]);
      e20 = sext(m_ff[6]); e21 = sext(m_ff[7]); e22 = sext(m_ff[8]);
      tr  = e00 + e11 + e22;
      d_x = '0; d_y = '0; d_z = '0; d_w = '0;
      side_in.kase = CASE_TRACE;
      if (!tr[SUM_W-1]) begin
         side_in.kase = CASE_TRACE;
         rad_s = tr + SUM_W'(ONE);
         d_x = e12 - e21; d_y = e20 - e02; d_z = e01 - e10;
         sa = d_x; sb = d_y; sc = d_z;
      end else if (e00 > e11 && e00 > e22) begin
         side_in.kase = CASE_X;
         rad_s = SUM_W'(ONE) + e00 - e11 - e22;
         d_y = e01 + e10; d_z = e20 + e02; d_w = e12 - e21;
         sa = d_y; sb = d_z; sc = d_w;
      end else if (e11 > e22) begin
         side_in.kase = CASE_Y;
         rad_s = SUM_W'(ONE) + e11 - e00 - e22;
         d_x = e01 + e10; d_z = e12 + e21; d_w = e20 - e02;
         sa = d_x; sb = d_z; sc = d_w;
      end else begin
         side_in.kase = CASE_Z;
         rad_s = SUM_W'(ONE) + e22 - e00 - e11;
         d_x = e20 + e02; d_y = e12 + e21; d_w = e01 - e10;
         sa = d_x; sb = d_y; sc = d_w;
      end
      // keep the divisor away from zero
      if (rad_s < SUM_W'(ONE)) rad_s = SUM_W'(ONE);
      rad_in = SQ_IN_W'(rad_s[RAD_W-1:0]) << FRAC_BITS;
      side_in.neg = {sc[SUM_W-1], sb[SUM_W-1], sa[SUM_W-1]};
      side_in.mag[0] = mag_of(sa);
      side_in.mag[1] = mag_of(sb);
      side_in.mag[2] = mag_of(sc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid;
         valid_ff    <= in_valid_ff;
      end
      m_ff    <= in_m;
      rad_ff  <= rad_in;
      side_ff <= side_in;
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;

endmodule

// ----- sv/rmq_sqrt.sv -----
// Integer square root, one result bit per pipeline stage.
module rmq_sqrt import rmq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [SQ_IN_W-1:0] in_rad,
   input  side_type           in_side,
   output logic               out_valid,
   output logic [S_W-1:0]     out_root,
   output side_type           out_side
);

   logic                valid_ff [S_W];
   logic [REM_W-1:0]    rem_ff   [S_W];
   logic [S_W-1:0]      root_ff  [S_W];
   logic [SQ_IN_W-1:0]  rad_ff   [S_W];
   side_type            side_ff  [S_W];

   for (genvar k = 0; k < S_W; k++) begin : g_stage
      logic               v_src;
      logic [REM_W-1:0]   rem_src, rem_in;
      logic [S_W-1:0]     root_src, root_in;
      logic [SQ_IN_W-1:0] rad_src;
      side_type           side_src;
      logic [CUR_W-1:0]   cur, sub;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = in_rad;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         cur = {rem_src, rad_src[SQ_IN_W-1 -: 2]};
         sub = CUR_W'({root_src, 2'b01});
         if (cur >= sub) begin
            rem_in  = REM_W'(cur - sub);
            root_in = {root_src[S_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(cur);
            root_in = {root_src[S_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_src;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_src << 2;
         side_ff[k] <= side_src;
      end
   end

   assign out_valid = valid_ff[S_W-1];
   assign out_root  = root_ff[S_W-1];
   assign out_side  = side_ff[S_W-1];

endmodule

// ----- sv/rmq_div.sv -----
// Three restoring dividers side by side, one quotient bit per pipeline stage.
module rmq_div import rmq_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [S_W-1:0]              in_root,
   input  side_type                    in_side,
   output logic                        out_valid,
   output logic [S_W-1:0]              out_root,
   output case_type                    out_kase,
   output logic [NSLOT-1:0]            out_neg,
   output logic [NSLOT-1:0][Q_W-1:0]   out_q
);

   logic                        valid_ff [Q_W];
   logic [S_W-1:0]              root_ff  [Q_W];
   case_type                    kase_ff  [Q_W];
   logic [NSLOT-1:0]            neg_ff   [Q_W];
   logic [NSLOT-1:0][DW-1:0]    rem_ff   [Q_W];
   logic [NSLOT-1:0][Q_W-1:0]   q_ff     [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic                      v_src;
      logic [S_W-1:0]            root_src;
      case_type                  kase_src;
      logic [NSLOT-1:0]          neg_src;
      logic [NSLOT-1:0][DW-1:0]  rem_src, rem_in;
      logic [NSLOT-1:0][Q_W-1:0] q_src, q_in;
      logic [DW-1:0]             shifted;

      if (k == 0) begin : g_first
         always_comb begin
            for (int j = 0; j < NSLOT; j++) begin
               rem_src[j] = DW'(in_side.mag[j]) << FRAC_BITS;
            end
         end
         assign v_src    = in_valid;
         assign root_src = in_root;
         assign kase_src = in_side.kase;
         assign neg_src  = in_side.neg;
         assign q_src    = '0;
      end else begin : g_next
         assign v_src    = valid_ff[k-1];
         assign root_src = root_ff[k-1];
         assign kase_src = kase_ff[k-1];
         assign neg_src  = neg_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign q_src    = q_ff[k-1];
      end

      // divisor is 2s, weighted by the bit this stage decides
      assign shifted = DW'({root_src, 1'b0}) << (Q_W - 1 - k);

      always_comb begin
         for (int j = 0; j < NSLOT; j++) begin
            if (rem_src[j] >= shifted) begin
               rem_in[j] = rem_src[j] - shifted;
               q_in[j]   = {q_src[j][Q_W-2:0], 1'b1};
            end else begin
               rem_in[j] = rem_src[j];
               q_in[j]   = {q_src[j][Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_src;
         end
         root_ff[k] <= root_src;
         kase_ff[k] <= kase_src;
         neg_ff[k]  <= neg_src;
         rem_ff[k]  <= rem_in;
         q_ff[k]    <= q_in;
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_root  = root_ff[Q_W-1];
   assign out_kase  = kase_ff[Q_W-1];
   assign out_neg   = neg_ff[Q_W-1];
   assign out_q     = q_ff[Q_W-1];

endmodule

// ----- sv/rotation_matrix_to_quaternion_top.sv -----
// Top level: rotation matrix to quaternion pipeline with command-style ports.
//
// Converts a 3x3 rotation matrix in signed Q1.14 into a quaternion by
// Shepperd's method. An item is taken whenever start is high; busy stays low
// after reset, so one matrix can enter every cycle. Each result appears on
// the rsp_ ports for one cycle with rsp_valid high, after the input and prep
// registers, the root stages, the quotient stages (16 each at Q1.14) and the
// output register, in the order the items came in. The receiver cannot stall
// the pipeline; capture each result in the cycle it is shown. The depth is set
// by the bit-per-stage square root and the bit-per-stage divider that follows
// it. rsp_case_taken reports the branch: 0 trace, 1 x, 2 y, 3 z largest.
// Results are truncated and saturated to plus or minus one.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [IN_W-1:0]  req_m00,
   input  logic [IN_W-1:0]  req_m01,
   input  logic [IN_W-1:0]  req_m02,
   input  logic [IN_W-1:0]  req_m10,
   input  logic [IN_W-1:0]  req_m11,
   input  logic [IN_W-1:0]  req_m12,
   input  logic [IN_W-1:0]  req_m20,
   input  logic [IN_W-1:0]  req_m21,
   input  logic [IN_W-1:0]  req_m22,
   output logic             rsp_valid,
   output logic [OUT_W-1:0] rsp_qx,
   output logic [OUT_W-1:0] rsp_qy,
   output logic [OUT_W-1:0] rsp_qz,
   output logic [OUT_W-1:0] rsp_qw,
   output logic [1:0]       rsp_case_taken
);

   logic                       prep_valid;
   logic [SQ_IN_W-1:0]         prep_rad;
   side_type                   prep_side;
   logic                       sq_valid;
   logic [S_W-1:0]             sq_root;
   side_type                   sq_side;
   logic                       dv_valid;
   logic [S_W-1:0]             dv_root;
   case_type                   dv_kase;
   logic [NSLOT-1:0]           dv_neg;
   logic [NSLOT-1:0][Q_W-1:0]  dv_q;

   logic                       valid_ff;
   logic [OUT_W-1:0]           qx_ff, qy_ff, qz_ff, qw_ff;
   logic [OUT_W-1:0]           qx_in, qy_in, qz_in, qw_in;
   logic [1:0]                 case_ff;
   logic [NSLOT-1:0][OUT_W-1:0] part;
   logic [OUT_W-1:0]           diag;
   logic [S_W-2:0]             half_s;

   // never hold off the requester
   assign busy = 1'b0;

   rmq_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_m      ({req_m22, req_m21, req_m20, req_m12, req_m11, req_m10,
                   req_m02, req_m01, req_m00}),
      .out_valid (prep_valid),
      .out_rad   (prep_rad),
      .out_side  (prep_side)
   );

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_rad    (prep_rad),
      .in_side   (prep_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_root  (dv_root),
      .out_kase  (dv_kase),
      .out_neg   (dv_neg),
      .out_q     (dv_q)
   );

   // apply sign and clamp to plus or minus one in Q1.14
   always_comb begin
      for (int j = 0; j < NSLOT; j++) begin
         if (dv_neg[j]) begin
            if (dv_q[j] > Q_W'(SAT_LO_MAG)) part[j] = OUT_W'(-SAT_LO_MAG);
            else                            part[j] = OUT_W'(-dv_q[j]);
         end else begin
            if (dv_q[j] > Q_W'(SAT_HI)) part[j] = OUT_W'(SAT_HI);
            else                        part[j] = OUT_W'(dv_q[j]);
         end
      end
      half_s = dv_root[S_W-1:1];
      if (S_W'(half_s) > S_W'(SAT_HI)) diag = OUT_W'(SAT_HI);
      else                             diag = OUT_W'(half_s);

      // route the three quotients around the diagonal component
      case (dv_kase)
         CASE_TRACE: begin
            qx_in = part[0]; qy_in = part[1]; qz_in = part[2]; qw_in = diag;
         end
         CASE_X: begin
            qx_in = diag; qy_in = part[0]; qz_in = part[1]; qw_in = part[2];
         end
         CASE_Y: begin
            qx_in = part[0]; qy_in = diag; qz_in = part[1]; qw_in = part[2];
         end
         default: begin
            qx_in = part[0]; qy_in = part[1]; qz_in = diag; qw_in = part[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dv_valid;
      end
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      qz_ff   <= qz_in;
      qw_ff   <= qw_in;
      case_ff <= dv_kase;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_qx         = qx_ff;
   assign rsp_qy         = qy_ff;
   assign rsp_qz         = qz_ff;
   assign rsp_qw         = qw_ff;
   assign rsp_case_taken = case_ff;

   // every accepted item comes out as a result with rsp_valid high
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("item lost in pipeline");

   // no result without an item that entered
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without item");

   // the diagonal component comes from s >= ONE, so it is strictly positive
   a_diag_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_case_taken == CASE_TRACE |-> !rsp_qw[OUT_W-1] && rsp_qw != '0)
      else $error("trace branch w not positive");

endmodule

// ----- bench/rmq_checker.sv -----
// Checker: watches the request and result ports, predicts quaternions, compares.
`timescale 1ns / 1ps
module rmq_checker import rmq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  logic [IN_W-1:0]  req_m00, req_m01, req_m02,
   input  logic [IN_W-1:0]  req_m10, req_m11, req_m12,
   input  logic [IN_W-1:0]  req_m20, req_m21, req_m22,
   input  logic             rsp_valid,
   input  logic [OUT_W-1:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw,
   input  logic [1:0]       rsp_case_taken,
   output int               fail_count,
   output int               pending,
   output int               case_hits [4]
);

   typedef struct packed {
      logic [15:0] qx, qy, qz, qw;
      case_type    kase;
   } quat_t;

   quat_t quat_q[$];

   function automatic longint clamp(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < -SAT_LO_MAG) return -SAT_LO_MAG;
      return v;
   endfunction

   function automatic longint int_root(longint v);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // d / 2s in fixed point, truncated toward zero
   function automatic longint scaled_part(longint d, longint s);
      longint q;
      q = ((d < 0 ? -d : d) << FRAC_BITS) / (2 * s);
      return clamp(d < 0 ? -q : q);
   endfunction

   function automatic quat_t to_quat(longint a00, a01, a02, a10, a11, a12,
                                     a20, a21, a22);
      longint tr, rad, s, x, y, z, w;
      quat_t  r;
      tr = a00 + a11 + a22;
      if (tr >= 0) begin
         r.kase = CASE_TRACE;  rad = tr + ONE;
      end else if (a00 > a11 && a00 > a22) begin
         r.kase = CASE_X;  rad = ONE + a00 - a11 - a22;
      end else if (a11 > a22) begin
         r.kase = CASE_Y;  rad = ONE + a11 - a00 - a22;
      end else begin
         r.kase = CASE_Z;  rad = ONE + a22 - a00 - a11;
      end
      if (rad < ONE) rad = ONE;
      s = int_root(rad << FRAC_BITS);
      if (s == 0) s = 1;
      case (r.kase)
         CASE_TRACE: begin
            w = clamp(s >>> 1);            x = scaled_part(a12 - a21, s);
            y = scaled_part(a20 - a02, s); z = scaled_part(a01 - a10, s);
         end
         CASE_X: begin
            x = clamp(s >>> 1);            y = scaled_part(a01 + a10, s);
            z = scaled_part(a20 + a02, s); w = scaled_part(a12 - a21, s);
         end
         CASE_Y: begin
            y = clamp(s >>> 1);            x = scaled_part(a01 + a10, s);
            z = scaled_part(a12 + a21, s); w = scaled_part(a20 - a02, s);
         end
         default: begin
            z = clamp(s >>> 1);            x = scaled_part(a20 + a02, s);
            y = scaled_part(a12 + a21, s); w = scaled_part(a01 - a10, s);
         end
      endcase
      r.qx = x[15:0]; r.qy = y[15:0]; r.qz = z[15:0]; r.qw = w[15:0];
      return r;
   endfunction

   assign pending = quat_q.size();

   initial begin
      fail_count = 0;
      foreach (case_hits[i]) case_hits[i] = 0;
   end

   always @(posedge clock) begin
      quat_t want, got;
      if (!reset) begin
         if (rsp_valid) begin
            got = {rsp_qx, rsp_qy, rsp_qz, rsp_qw, case_type'(rsp_case_taken)};
            if (quat_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %p", got);
            end else begin
               want = quat_q.pop_front();
               case_hits[want.kase]++;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) $display("bad result: want %p got %p", want, got);
               end
            end
         end
         if (start && !busy)
            quat_q.push_back(to_quat(
               $signed(req_m00), $signed(req_m01), $signed(req_m02),
               $signed(req_m10), $signed(req_m11), $signed(req_m12),
               $signed(req_m20), $signed(req_m21), $signed(req_m22)));
      end
   end

endmodule

// ----- bench/tb.sv -----
// Testbench top: drives matrices into the block and reports the verdict.
`timescale 1ns / 1ps
module tb;
   import rmq_pkg::*;

   localparam int RANDOM_ITEMS = 1950;

   logic clock = 0, reset = 1, start = 0, busy;
   logic [IN_W-1:0] m [9];
   logic rsp_valid;
   logic [OUT_W-1:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw;
   logic [1:0] rsp_case_taken;
   int fail_count, pending, case_hits [4], sent;

   always #5 clock = ~clock;

   rotation_matrix_to_quaternion_top u_dut (
      .clock, .reset, .start, .busy,
      .req_m00(m[0]), .req_m01(m[1]), .req_m02(m[2]),
      .req_m10(m[3]), .req_m11(m[4]), .req_m12(m[5]),
      .req_m20(m[6]), .req_m21(m[7]), .req_m22(m[8]),
      .rsp_valid, .rsp_qx, .rsp_qy, .rsp_qz, .rsp_qw, .rsp_case_taken);

   rmq_checker u_chk (
      .clock, .reset, .start, .busy,
      .req_m00(m[0]), .req_m01(m[1]), .req_m02(m[2]),
      .req_m10(m[3]), .req_m11(m[4]), .req_m12(m[5]),
      .req_m20(m[6]), .req_m21(m[7]), .req_m22(m[8]),
      .rsp_valid, .rsp_qx, .rsp_qy, .rsp_qz, .rsp_qw, .rsp_case_taken,
      .fail_count, .pending, .case_hits);

   // Hold one matrix on the ports until the block takes it; start stays high
   // across back-to-back items, so it is only lowered by the caller.
   task automatic send_item(input logic [15:0] v [9]);
      for (int i = 0; i < 9; i++) m[i] <= v[i];
      start <= 1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent++;
   endtask

   task automatic idle(input int n);
      start <= 0;
      repeat (n) @(negedge clock);
   endtask

   // Mostly in-range elements; sometimes full 16-bit noise to reach saturation.
   function automatic logic [15:0] pick_elem(int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 2 * ONE) - ONE);
         default: return ($urandom_range(0, 1)) ? 16'(ONE) : 16'(-ONE);
      endcase
   endfunction

   initial begin
      logic [15:0] v [9];
      int burst, mode, dom;
      sent = 0;
      foreach (m[i]) m[i] = '0;
      repeat (12) @(negedge clock);
      reset = 0;

      // Directed: identity, half-turns about each axis (x, y, z branches),
      // diagonal ties, a quarter turn about z, extreme 16-bit values and out-of-range inputs.
      v = '{16'(ONE),0,0, 0,16'(ONE),0, 0,0,16'(ONE)};               send_item(v);
      v = '{16'(ONE),0,0, 0,16'(-ONE),0, 0,0,16'(-ONE)};             send_item(v);
      v = '{16'(-ONE),0,0, 0,16'(ONE),0, 0,0,16'(-ONE)};             send_item(v);
      v = '{16'(-ONE),0,0, 0,16'(-ONE),0, 0,0,16'(ONE)};             send_item(v);
      v = '{16'(-100),0,0, 0,16'(-100),0, 0,0,16'(-300)};            send_item(v);
      v = '{16'(-100),0,0, 0,16'(-300),0, 0,0,16'(-100)};            send_item(v);
      v = '{16'(-200),0,0, 0,16'(-200),0, 0,0,16'(-200)};            send_item(v);
      v = '{0,16'(ONE),0, 16'(-ONE),0,0, 0,0,16'(ONE)};              send_item(v);
      v = '{16'h8000,16'h7fff,16'h8000, 16'h7fff,16'h8000,16'h7fff,
            16'h8000,16'h7fff,16'h8000};                             send_item(v);
      v = '{16'h7fff,16'h8000,16'h7fff, 16'h8000,16'h7fff,16'h8000,
            16'h7fff,16'h8000,16'h7fff};                             send_item(v);
      v = '{16'h8000,16'h7fff,16'h7fff, 16'h7fff,16'h8000,16'h7fff,
            16'h7fff,16'h7fff,16'h7fff};                             send_item(v);
      v = '{16'hffff,16'h8000,16'h8000, 16'h8000,16'h8000,16'h8000,
            16'h8000,16'h8000,16'h8000};                             send_item(v);
      v = '{0,16'h7fff,16'h8000, 16'h8000,0,16'h7fff,
            16'h7fff,16'h8000,0};                                    send_item(v);
      v = '{16'hffff,16'hffff,16'hffff, 16'hffff,16'hffff,16'hffff,
            16'hffff,16'hffff,16'hffff};                             send_item(v);

      // Drain fully once before the random part.
      idle(1);
      while (pending != 0) @(negedge clock);

      while (sent < RANDOM_ITEMS + 14) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            mode = ($urandom_range(0, 9) == 0) ? 0 : ($urandom_range(0, 9) == 0 ? 2 : 1);
            foreach (v[i]) v[i] = pick_elem(mode);
            // Half the time, bias toward a negative trace and a chosen dominant diagonal.
            if (mode == 1 && $urandom_range(0, 1)) begin
               dom = $urandom_range(0, 2);
               for (int k = 0; k < 3; k++)
                  v[4*k] = 16'(-$urandom_range(0, ONE));
               v[4*dom] = 16'($urandom_range(0, ONE) - ONE / 2);
            end
            send_item(v);
         end
         if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 50));
      end
      idle(1);

      fork
         begin
            while (pending != 0) @(negedge clock);
            repeat (LATENCY + 10) @(negedge clock);
         end
         begin
            repeat (10 * LATENCY + 200) @(negedge clock);
         end
      join_any

      $display("sent %0d matrices; branches trace/x/y/z = %0d/%0d/%0d/%0d",
               sent, case_hits[0], case_hits[1], case_hits[2], case_hits[3]);
      if (fail_count == 0 && pending == 0) begin
         $display("rotation_matrix_to_quaternion_top: match");
      end else begin
         $display("rotation_matrix_to_quaternion_top: mismatch");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("rotation_matrix_to_quaternion_top: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/rmq_pkg.sv
sv/rmq_prep.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion_top.sv
bench/rmq_checker.sv
bench/tb.sv
